### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions in the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies something in the next cycle.
`define ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

### src/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Types and constants shared by the shape drawing engine modules.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 296;

  // Coordinate width: circle points reach twice the input range.
  localparam int CW = 12;
  // Width of the Bresenham and midpoint error terms.
  localparam int EW = 16;
  // Width of the byte address arithmetic before the range check.
  localparam int ADDR_CALC_W = 17;

  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef enum logic [2:0] {
    ACT_CLEAR       = 3'd0,
    ACT_PIXEL       = 3'd1,
    ACT_LINE        = 3'd2,
    ACT_RECT        = 3'd3,
    ACT_FILL_RECT   = 3'd4,
    ACT_CIRCLE      = 3'd5,
    ACT_FILL_CIRCLE = 3'd6,
    ACT_READ        = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    REG_ROTATION = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_POLARITY = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    action_e           action;
    logic signed [9:0] x0;
    logic signed [9:0] y0;
    logic signed [9:0] x1;
    logic signed [9:0] y1;
    logic [8:0]        radius;
  } shape_cmd_t;

endpackage

### src/mse_map.sv
// ----------------------------------------------------------------------------
// mse_map
// Rotates a logical pixel, clips it to the region and forms its byte address.
// ----------------------------------------------------------------------------
module mse_map #(
  parameter int PANEL_WIDTH  = mse_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mse_pkg::DEF_PANEL_HEIGHT,
  parameter int AW           = $clog2((PANEL_WIDTH / 8) * PANEL_HEIGHT)
) (
  input  logic signed [mse_pkg::CW-1:0] x_i,
  input  logic signed [mse_pkg::CW-1:0] y_i,
  input  logic [1:0]                    rot_i,
  input  logic [7:0]                    w_i,
  input  logic [8:0]                    h_i,
  output logic                          ok_o,
  output logic [AW-1:0]                 addr_o,
  output logic [2:0]                    bit_o
);
  import mse_pkg::*;

  localparam int FRAME_BYTES = (PANEL_WIDTH / 8) * PANEL_HEIGHT;

  logic signed [CW-1:0] ws, hs, bx, by, ax, ay;
  logic                 in_rng;
  logic [ADDR_CALC_W-1:0] addr_full;

  assign ws = $signed({{(CW-8){1'b0}}, w_i});
  assign hs = $signed({{(CW-9){1'b0}}, h_i});
  assign bx = rot_i[0] ? hs : ws;
  assign by = rot_i[0] ? ws : hs;
  assign in_rng = !x_i[CW-1] && !y_i[CW-1] && (x_i < bx) && (y_i < by);

  always_comb begin
    case (rot_i)
      2'd0: begin
        ax = x_i;
        ay = y_i;
      end
      2'd1: begin
        ax = ws - CW'(1) - y_i;
        ay = x_i;
      end
      2'd2: begin
        ax = ws - CW'(1) - x_i;
        ay = hs - CW'(1) - y_i;
      end
      default: begin
        ax = y_i;
        ay = hs - CW'(1) - x_i;
      end
    endcase
  end

  // Rows hold w/8 bytes, so the byte address is row * (w/8) + column / 8.
  assign addr_full = ADDR_CALC_W'(ay[8:0]) * ADDR_CALC_W'(w_i[7:3])
                   + ADDR_CALC_W'(ax[7:3]);
  assign ok_o   = in_rng && (addr_full < ADDR_CALC_W'(FRAME_BYTES));
  assign addr_o = addr_full[AW-1:0];
  assign bit_o  = ax[2:0];

endmodule

### src/mse_walk.sv
// ----------------------------------------------------------------------------
// mse_walk
// Shape sequencer: steps through the pixels of a line, rectangle or circle.
// ----------------------------------------------------------------------------
module mse_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  mse_pkg::shape_cmd_t           cmd_i,
  input  logic                          adv_i,
  output logic                          busy_o,
  output logic signed [mse_pkg::CW-1:0] x_o,
  output logic signed [mse_pkg::CW-1:0] y_o
);
  import mse_pkg::*;

  logic                 busy_q, busy_d;
  action_e              act_q, act_d;
  logic signed [CW-1:0] px_q, px_d, py_q, py_d;
  logic signed [CW-1:0] lox_q, lox_d, hix_q, hix_d, loy_q, loy_d, hiy_q, hiy_d;
  logic signed [CW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [CW-1:0] xp_q, xp_d, yp_q, yp_d;
  logic signed [EW-1:0] err_q, err_d;
  logic [1:0]           ph_q, ph_d;
  logic                 sx_q, sx_d, sy_q, sy_d;

  logic signed [CW-1:0] x0e, y0e, x1e, y1e, rad, cxr;
  logic signed [EW-1:0] e2, c_e2, c_err;
  logic signed [CW-1:0] c_xp, c_yp;

  assign x0e = CW'(cmd_i.x0);
  assign y0e = CW'(cmd_i.y0);
  assign x1e = CW'(cmd_i.x1);
  assign y1e = CW'(cmd_i.y1);
  assign rad = $signed({{(CW-9){1'b0}}, cmd_i.radius});
  assign cxr = lox_q - xp_q;

  // One midpoint circle step.
  always_comb begin
    c_xp  = xp_q;
    c_yp  = yp_q;
    c_err = err_q;
    c_e2  = err_q;
    if (err_q <= EW'(yp_q)) begin
      c_yp  = yp_q + CW'(1);
      c_err = c_err + EW'(c_yp) + EW'(c_yp) + EW'(1);
      if ((-xp_q == c_yp) && (err_q <= EW'(xp_q))) begin
        c_e2 = '0;
      end
    end
    if (c_e2 > EW'(xp_q)) begin
      c_xp  = xp_q + CW'(1);
      c_err = c_err + EW'(c_xp) + EW'(c_xp) + EW'(1);
    end
  end

  assign e2 = err_q + err_q;

  always_comb begin
    busy_d = busy_q;
    act_d  = act_q;
    px_d   = px_q;
    py_d   = py_q;
    lox_d  = lox_q;
    hix_d  = hix_q;
    loy_d  = loy_q;
    hiy_d  = hiy_q;
    dx_d   = dx_q;
    dy_d   = dy_q;
    xp_d   = xp_q;
    yp_d   = yp_q;
    err_d  = err_q;
    ph_d   = ph_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    if (start_i) begin
      busy_d = 1'b1;
      act_d  = cmd_i.action;
      lox_d  = (x0e < x1e) ? x0e : x1e;
      hix_d  = (x0e < x1e) ? x1e : x0e;
      loy_d  = (y0e < y1e) ? y0e : y1e;
      hiy_d  = (y0e < y1e) ? y1e : y0e;
      px_d   = x0e;
      py_d   = y0e;
      dx_d   = (x1e >= x0e) ? (x1e - x0e) : (x0e - x1e);
      dy_d   = (y1e >= y0e) ? (y0e - y1e) : (y1e - y0e);
      sx_d   = x0e < x1e;
      sy_d   = y0e < y1e;
      err_d  = EW'(dx_d) + EW'(dy_d);
      ph_d   = 2'd0;
      case (cmd_i.action)
        ACT_LINE: begin
          hix_d = x1e;
          hiy_d = y1e;
        end
        ACT_RECT, ACT_FILL_RECT: begin
          px_d = lox_d;
          py_d = loy_d;
        end
        ACT_CIRCLE, ACT_FILL_CIRCLE: begin
          lox_d = x0e;
          loy_d = y0e;
          xp_d  = -rad;
          yp_d  = '0;
          err_d = EW'(2) - EW'(rad) - EW'(rad);
          px_d  = x0e - rad;
        end
        default: ;
      endcase
    end else if (adv_i && busy_q) begin
      case (act_q)
        ACT_LINE: begin
          if ((px_q == hix_q) && (py_q == hiy_q)) begin
            busy_d = 1'b0;
          end else begin
            if (e2 >= EW'(dy_q)) begin
              err_d = err_d + EW'(dy_q);
              px_d  = sx_q ? px_q + CW'(1) : px_q - CW'(1);
            end
            if (e2 <= EW'(dx_q)) begin
              err_d = err_d + EW'(dx_q);
              py_d  = sy_q ? py_q + CW'(1) : py_q - CW'(1);
            end
          end
        end
        ACT_RECT: begin
          if (!ph_q[1]) begin
            if (px_q == hix_q) begin
              ph_d = ph_q + 2'd1;
              px_d = lox_q;
              py_d = ph_q[0] ? loy_q : hiy_q;
            end else begin
              px_d = px_q + CW'(1);
            end
          end else begin
            if (py_q == hiy_q) begin
              if (ph_q[0]) begin
                busy_d = 1'b0;
              end else begin
                ph_d = 2'd3;
                px_d = hix_q;
                py_d = loy_q;
              end
            end else begin
              py_d = py_q + CW'(1);
            end
          end
        end
        ACT_FILL_RECT: begin
          if (px_q == hix_q) begin
            if (py_q == hiy_q) begin
              busy_d = 1'b0;
            end else begin
              px_d = lox_q;
              py_d = py_q + CW'(1);
            end
          end else begin
            px_d = px_q + CW'(1);
          end
        end
        ACT_CIRCLE: begin
          if (ph_q != 2'd3) begin
            ph_d = ph_q + 2'd1;
          end else begin
            ph_d  = 2'd0;
            xp_d  = c_xp;
            yp_d  = c_yp;
            err_d = c_err;
            if (c_xp > CW'(0)) begin
              busy_d = 1'b0;
            end
          end
        end
        ACT_FILL_CIRCLE: begin
          if (px_q == cxr) begin
            if (ph_q == 2'd0) begin
              ph_d = 2'd1;
              px_d = lox_q + xp_q;
            end else begin
              ph_d  = 2'd0;
              xp_d  = c_xp;
              yp_d  = c_yp;
              err_d = c_err;
              px_d  = lox_q + c_xp;
              if (c_xp > CW'(0)) begin
                busy_d = 1'b0;
              end
            end
          end else begin
            px_d = px_q + CW'(1);
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (act_q)
      ACT_CIRCLE: begin
        x_o = (ph_q == 2'd0 || ph_q == 2'd3) ? cxr : (lox_q + xp_q);
        y_o = ph_q[1] ? (loy_q - yp_q) : (loy_q + yp_q);
      end
      ACT_FILL_CIRCLE: begin
        x_o = px_q;
        y_o = ph_q[0] ? (loy_q - yp_q) : (loy_q + yp_q);
      end
      default: begin
        x_o = px_q;
        y_o = py_q;
      end
    endcase
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      act_q  <= ACT_PIXEL;
      ph_q   <= 2'd0;
    end else begin
      busy_q <= busy_d;
      act_q  <= act_d;
      ph_q   <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    lox_q <= lox_d;
    hix_q <= hix_d;
    loy_q <= loy_d;
    hiy_q <= hiy_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    xp_q  <= xp_d;
    yp_q  <= yp_d;
    err_q <= err_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
  end

endmodule

### src/monochrome_shape_drawing_engine.sv
// ----------------------------------------------------------------------------
// monochrome_shape_drawing_engine
// One-bit-per-pixel frame store with a line, rectangle and circle rasterizer.
// ----------------------------------------------------------------------------
// Each command item draws into the frame store, clears it or reads one byte
// back, and answers with exactly one result item; the block takes one command
// at a time and drops s_axis_tready until the result is handed to the output
// register. The rate is set by the frame memory and the shape sequencer,
// which produces one pixel per step: a pixel inside the region takes a read
// and a write back of its byte, a clipped pixel only the sequencer step. A
// circle outline visits four points per midpoint step and a filled circle
// the pixels of its two spans per step. A clear writes one byte a cycle over
// the region. The frame store comes out of reset undefined; read only bytes
// already written by a clear or a draw. Configuration writes are always
// accepted and should be issued only while no command is in flight.
module monochrome_shape_drawing_engine #(
  parameter int PANEL_WIDTH  = mse_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mse_pkg::DEF_PANEL_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x0[9:0], y0[19:10], x1[29:20], y1[39:30], radius[48:40], colored[49],
  // byte_index[62:50], zero pad[63]
  input  logic [63:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata,
  // is_read[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import mse_pkg::*;

  `include "assert_macros.svh"

  localparam int FRAME_BYTES = (PANEL_WIDTH / 8) * PANEL_HEIGHT;
  localparam int AW          = $clog2(FRAME_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_PIX  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Configuration registers.
  logic [1:0] rot_q;
  logic [7:0] wid_q;
  logic [8:0] hgt_q;
  logic       pol_q;
  logic [7:0] w_eff;

  assign cfg_ready_o = 1'b1;
  assign w_eff       = {wid_q[7:3], 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= 2'd0;
      wid_q <= 8'd128;
      hgt_q <= 9'd296;
      pol_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROTATION: rot_q <= cfg_data_i[1:0];
        REG_WIDTH:    wid_q <= cfg_data_i[7:0];
        REG_HEIGHT:   hgt_q <= cfg_data_i;
        REG_POLARITY: pol_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Command decode.
  shape_cmd_t cmd;
  logic       in_ink;
  logic [12:0] in_bidx;
  logic       accept;

  assign cmd.action = action_e'(s_axis_tuser);
  assign cmd.x0     = s_axis_tdata[9:0];
  assign cmd.y0     = s_axis_tdata[19:10];
  assign cmd.x1     = s_axis_tdata[29:20];
  assign cmd.y1     = s_axis_tdata[39:30];
  assign cmd.radius = s_axis_tdata[48:40];
  assign in_ink     = s_axis_tdata[49];
  assign in_bidx    = s_axis_tdata[62:50];

  logic [2:0]  state_q, state_d;
  logic        ink_q;
  logic        is_read_q;
  logic        rd_ok_q;
  logic [AW-1:0] bidx_q;
  logic [AW:0] clr_cnt_q, clr_n_q;
  logic [7:0]  fill_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]  mask_q;

  logic [ADDR_CALC_W-1:0] clr_full, rd_full;
  logic [AW:0] clr_n;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign clr_full = ADDR_CALC_W'(w_eff[7:3]) * ADDR_CALC_W'(hgt_q);
  assign clr_n    = (clr_full < ADDR_CALC_W'(FRAME_BYTES)) ? clr_full[AW:0]
                                                          : (AW+1)'(FRAME_BYTES);
  assign rd_full  = ADDR_CALC_W'(in_bidx);

  // Shape sequencer and pixel mapper.
  logic                 walk_start, walk_adv, walk_busy;
  logic signed [CW-1:0] pt_x, pt_y;
  logic                 map_ok;
  logic [AW-1:0]        map_addr;
  logic [2:0]           map_bit;

  assign walk_start = accept && (cmd.action inside {ACT_PIXEL, ACT_LINE, ACT_RECT,
                                                    ACT_FILL_RECT, ACT_CIRCLE,
                                                    ACT_FILL_CIRCLE});
  assign walk_adv   = (state_q == S_WR) ||
                      ((state_q == S_PIX) && walk_busy && !map_ok);

  mse_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .cmd_i   (cmd),
    .adv_i   (walk_adv),
    .busy_o  (walk_busy),
    .x_o     (pt_x),
    .y_o     (pt_y)
  );

  mse_map #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .AW           (AW)
  ) u_map (
    .x_i    (pt_x),
    .y_i    (pt_y),
    .rot_i  (rot_q),
    .w_i    (w_eff),
    .h_i    (hgt_q),
    .ok_o   (map_ok),
    .addr_o (map_addr),
    .bit_o  (map_bit)
  );

  // Frame memory: one write and one registered read port.
  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    mem_rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, merged;

  assign merged    = (ink_q == pol_q) ? (mem_rdata_q | mask_q) : (mem_rdata_q & ~mask_q);
  assign mem_we    = (state_q == S_CLR) || (state_q == S_WR);
  assign mem_waddr = (state_q == S_CLR) ? clr_cnt_q[AW-1:0] : wr_addr_q;
  assign mem_wdata = (state_q == S_CLR) ? fill_q : merged;
  assign mem_re    = (state_q == S_RD) || ((state_q == S_PIX) && walk_busy && map_ok);
  assign mem_raddr = (state_q == S_RD) ? bidx_q : map_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_CLEAR: state_d = (clr_n == '0) ? S_DONE : S_CLR;
            ACT_READ:  state_d = S_RD;
            default:   state_d = S_PIX;
          endcase
        end
      end
      S_CLR:  if (clr_cnt_q == clr_n_q - (AW+1)'(1)) state_d = S_DONE;
      S_PIX: begin
        if (!walk_busy) begin
          state_d = S_DONE;
        end else if (map_ok) begin
          state_d = S_WR;
        end
      end
      S_WR:   state_d = S_PIX;
      S_RD:   state_d = S_DONE;
      S_DONE: if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ink_q     <= in_ink;
      is_read_q <= (cmd.action == ACT_READ);
      rd_ok_q   <= rd_full < ADDR_CALC_W'(FRAME_BYTES);
      bidx_q    <= rd_full[AW-1:0];
      clr_n_q   <= clr_n;
      clr_cnt_q <= '0;
      fill_q    <= (in_ink == pol_q) ? 8'hFF : 8'h00;
    end else if (state_q == S_CLR) begin
      clr_cnt_q <= clr_cnt_q + (AW+1)'(1);
    end
    if (state_q == S_PIX && map_ok) begin
      wr_addr_q <= map_addr;
      mask_q    <= MSB_MASK >> map_bit;
    end
    if (state_q == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser <= is_read_q;
      m_axis_tdata <= (is_read_q && rd_ok_q) ? mem_rdata_q : 8'h00;
    end
  end

  `ASSERT_CLK(a_wr_after_pix, (state_q != S_WR) || ($past(state_q) == S_PIX),
              "pixel write without a preceding read")
  `ASSERT_CLK(a_clr_in_range, (state_q != S_CLR) || (clr_cnt_q < clr_n_q),
              "clear counter past region end")
  `ASSERT_NEXT(a_done_delivers, (state_q == S_DONE) && !m_axis_tvalid, m_axis_tvalid,
               "finished command did not produce a result")

endmodule

### verif/monochrome_shape_drawing_engine_tb.sv
// ----------------------------------------------------------------------------
// monochrome_shape_drawing_engine_tb
// Self-checking testbench for the shape drawing engine.
// ----------------------------------------------------------------------------
// Commands go in over the slave stream and one answer per command comes out of the
// master stream. A scoreboard keeps its own copy of the frame store, runs
// every accepted command through a rasterizer of its own, and compares each
// result item with the oldest prediction. The run starts with directed
// extremes and then goes through several region settings with random
// commands, random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module monochrome_shape_drawing_engine_tb;
  import mse_pkg::*;

  localparam int STORE_BYTES = (DEF_PANEL_WIDTH / 8) * DEF_PANEL_HEIGHT;
  localparam int STALL_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    action_e act;
    int      x0;
    int      y0;
    int      x1;
    int      y1;
    int      rad;
    bit      ink;
    int      idx;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       is_read;
  } answer_t;

  // Scoreboard: holds a private frame store and the queue of predicted answers.
  class frame_scoreboard;
    byte unsigned frame[STORE_BYTES];
    int           rot;
    int           w_reg;
    int           h_reg;
    bit           pol;
    answer_t      answers[$];

    function void set_reg(cfg_reg_e idx, int val);
      case (idx)
        REG_ROTATION: rot   = val & 3;
        REG_WIDTH:    w_reg = val & 'hFF;
        REG_HEIGHT:   h_reg = val & 'h1FF;
        REG_POLARITY: pol   = val & 1;
        default: ;
      endcase
    endfunction

    function int reg_w();
      return w_reg & 'hF8;
    endfunction

    function void put_abs(int ax, int ay, bit ink);
      int w;
      int addr;
      byte unsigned mask;
      w = reg_w();
      if (ax < 0 || ax >= w || ay < 0 || ay >= h_reg) return;
      addr = (ax + ay * w) / 8;
      if (addr >= STORE_BYTES) return;
      mask = 8'h80 >> (ax & 7);
      if (ink == pol) frame[addr] |= mask;
      else frame[addr] &= ~mask;
    endfunction

    function void plot(int x, int y, bit ink);
      int w;
      int h;
      w = reg_w();
      h = h_reg;
      case (rot)
        0: put_abs(x, y, ink);
        1: if (!(x < 0 || x >= h || y < 0 || y >= w)) put_abs(w - 1 - y, x, ink);
        2: if (!(x < 0 || x >= w || y < 0 || y >= h)) put_abs(w - 1 - x, h - 1 - y, ink);
        default: if (!(x < 0 || x >= h || y < 0 || y >= w)) put_abs(y, h - 1 - x, ink);
      endcase
    endfunction

    function void span(int x, int y, int len, bit ink);
      for (int i = x; i < x + len; i++) plot(i, y, ink);
    endfunction

    function void column(int x, int y, int len, bit ink);
      for (int i = y; i < y + len; i++) plot(x, i, ink);
    endfunction

    // Bresenham walk, both end points included.
    function void draw_line(int xa, int ya, int xb, int yb, bit ink);
      int dx;
      int dy;
      int sx;
      int sy;
      int err;
      int e2;
      dx = (xb >= xa) ? xb - xa : xa - xb;
      dy = (yb >= ya) ? ya - yb : yb - ya;
      sx = (xa < xb) ? 1 : -1;
      sy = (ya < yb) ? 1 : -1;
      err = dx + dy;
      forever begin
        plot(xa, ya, ink);
        if (xa == xb && ya == yb) break;
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          xa += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          ya += sy;
        end
      end
    endfunction

    // Midpoint circle; the filled form adds two spans per step.
    function void draw_circle(int cx, int cy, int r, bit ink, bit fill);
      int xp;
      int yp;
      int err;
      int e2;
      xp = -r;
      yp = 0;
      err = 2 - 2 * r;
      do begin
        plot(cx - xp, cy + yp, ink);
        plot(cx + xp, cy + yp, ink);
        plot(cx + xp, cy - yp, ink);
        plot(cx - xp, cy - yp, ink);
        if (fill) begin
          span(cx + xp, cy + yp, 2 * (-xp) + 1, ink);
          span(cx + xp, cy - yp, 2 * (-xp) + 1, ink);
        end
        e2 = err;
        if (e2 <= yp) begin
          yp++;
          err += yp * 2 + 1;
          if (-xp == yp && e2 <= xp) e2 = 0;
        end
        if (e2 > xp) begin
          xp++;
          err += xp * 2 + 1;
        end
      end while (xp <= 0);
    endfunction

    // Notes an accepted command: updates the frame and predicts its answer.
    function void note_cmd(draw_cmd_t c);
      answer_t a;
      int lx;
      int hx;
      int ly;
      int hy;
      int n;
      lx = (c.x0 < c.x1) ? c.x0 : c.x1;
      hx = (c.x0 < c.x1) ? c.x1 : c.x0;
      ly = (c.y0 < c.y1) ? c.y0 : c.y1;
      hy = (c.y0 < c.y1) ? c.y1 : c.y0;
      a.data = 8'h00;
      a.is_read = 1'b0;
      case (c.act)
        ACT_CLEAR: begin
          n = (reg_w() / 8) * h_reg;
          if (n > STORE_BYTES) n = STORE_BYTES;
          for (int i = 0; i < n; i++) frame[i] = (c.ink == pol) ? 8'hFF : 8'h00;
        end
        ACT_PIXEL: plot(c.x0, c.y0, c.ink);
        ACT_LINE:  draw_line(c.x0, c.y0, c.x1, c.y1, c.ink);
        ACT_RECT: begin
          span(lx, ly, hx - lx + 1, c.ink);
          span(lx, hy, hx - lx + 1, c.ink);
          column(lx, ly, hy - ly + 1, c.ink);
          column(hx, ly, hy - ly + 1, c.ink);
        end
        ACT_FILL_RECT: for (int i = lx; i <= hx; i++) column(i, ly, hy - ly + 1, c.ink);
        ACT_CIRCLE:      draw_circle(c.x0, c.y0, c.rad, c.ink, 1'b0);
        ACT_FILL_CIRCLE: draw_circle(c.x0, c.y0, c.rad, c.ink, 1'b1);
        default: begin
          a.data = (c.idx < STORE_BYTES) ? frame[c.idx] : 8'h00;
          a.is_read = 1'b1;
        end
      endcase
      answers.push_back(a);
    endfunction

    // Pops the oldest prediction; returns 0 when none was waiting.
    function bit take_answer(output answer_t a);
      if (answers.size() == 0) return 1'b0;
      a = answers.pop_front();
      return 1'b1;
    endfunction

    function int pending();
      return answers.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_data_i;

  monochrome_shape_drawing_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  frame_scoreboard sb = new();
  int              mismatches = 0;
  int              reads_checked = 0;
  int              cmds_by_action[8];
  bit              idle_on = 1'b0;
  bit              long_hold = 1'b0;
  int              quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Rebuilds the command that the input ports carry at this edge.
  function automatic draw_cmd_t port_cmd();
    draw_cmd_t c;
    c.act = action_e'(s_axis_tuser);
    c.x0  = int'($signed(s_axis_tdata[9:0]));
    c.y0  = int'($signed(s_axis_tdata[19:10]));
    c.x1  = int'($signed(s_axis_tdata[29:20]));
    c.y1  = int'($signed(s_axis_tdata[39:30]));
    c.rad = int'(s_axis_tdata[48:40]);
    c.ink = s_axis_tdata[49];
    c.idx = int'(s_axis_tdata[62:50]);
    return c;
  endfunction

  // Accepted command items update the scoreboard before the result of the same
  // edge is compared; a result can never belong to a command accepted there.
  always @(posedge clk_i) begin
    answer_t a;
    draw_cmd_t c;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c = port_cmd();
      sb.note_cmd(c);
      cmds_by_action[c.act]++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (!sb.take_answer(a)) begin
        report($sformatf("unexpected result data=%02h is_read=%0b",
                         m_axis_tdata, m_axis_tuser));
      end else begin
        if (a.is_read) reads_checked++;
        if (m_axis_tdata !== a.data)
          report($sformatf("read_data %02h, predicted %02h", m_axis_tdata, a.data));
        if (m_axis_tuser !== a.is_read)
          report($sformatf("is_read %0b, predicted %0b", m_axis_tuser, a.is_read));
      end
    end
  end

  // Watchdog on cycles in which no item moves on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("** monochrome_shape_drawing_engine: FAILED **");
      $finish;
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request so
  // that the engine fills up and pushes back on its input.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offers one command and returns at the edge that accepts it.
  task automatic send_cmd(draw_cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.act;
    s_axis_tdata  <= {1'b0, c.idx[12:0], c.ink, c.rad[8:0], c.y1[9:0], c.x1[9:0],
                      c.y0[9:0], c.x0[9:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Lowers the command valid and waits until every answer has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[8:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic draw_cmd_t make_cmd(action_e act, int x0, int y0, int x1, int y1,
                                         int rad, bit ink, int idx);
    draw_cmd_t c;
    c.act = act;
    c.x0 = x0;
    c.y0 = y0;
    c.x1 = x1;
    c.y1 = y1;
    c.rad = rad;
    c.ink = ink;
    c.idx = idx;
    return c;
  endfunction

  // Mostly near the region, now and then anywhere in the signed field range.
  function automatic int pick_coord(int lim);
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 1023)) - 512;
    return int'($urandom_range(0, lim + 16)) - 8;
  endfunction

  // Reads touch only bytes written by the clear that opens each phase, or
  // addresses past the store, which always answer zero.
  function automatic int pick_byte();
    int n;
    n = (sb.reg_w() / 8) * sb.h_reg;
    if (n > STORE_BYTES) n = STORE_BYTES;
    if ($urandom_range(0, 5) == 0) return $urandom_range(STORE_BYTES, 8191);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int lim;
    int pick;
    lim = (sb.reg_w() > sb.h_reg) ? sb.reg_w() : sb.h_reg;
    pick = $urandom_range(0, 99);
    c = make_cmd(ACT_READ, pick_coord(lim), pick_coord(lim), pick_coord(lim),
                 pick_coord(lim), $urandom_range(0, 511), $urandom_range(0, 1),
                 $urandom_range(0, 8191));
    if (pick < 3) c.act = ACT_CLEAR;
    else if (pick < 20) c.act = ACT_PIXEL;
    else if (pick < 35) c.act = ACT_LINE;
    else if (pick < 45) c.act = ACT_RECT;
    else if (pick < 53) c.act = ACT_FILL_RECT;
    else if (pick < 63) c.act = ACT_CIRCLE;
    else if (pick < 70) c.act = ACT_FILL_CIRCLE;
    else c.act = ACT_READ;
    // Keep the slow shapes small so the run stays short.
    if (c.act == ACT_FILL_RECT || c.act == ACT_RECT) begin
      c.x0 = int'($urandom_range(0, lim + 16)) - 8;
      c.y0 = int'($urandom_range(0, lim + 16)) - 8;
      c.x1 = c.x0 + int'($urandom_range(0, 40)) - 20;
      c.y1 = c.y0 + int'($urandom_range(0, 40)) - 20;
    end
    if (c.act == ACT_CIRCLE) c.rad = $urandom_range(0, 60);
    if (c.act == ACT_FILL_CIRCLE) c.rad = $urandom_range(0, 24);
    if (c.act == ACT_READ) c.idx = pick_byte();
    return c;
  endfunction

  initial begin
    int w;
    int h;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_CLEAR;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ROTATION;
    cfg_data_i    = '0;
    sb.set_reg(REG_ROTATION, 0);
    sb.set_reg(REG_WIDTH, 128);
    sb.set_reg(REG_HEIGHT, 296);
    sb.set_reg(REG_POLARITY, 0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings: full-region clear, field extremes,
    // every shape, both inks, and reads at the ends of the address range.
    send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 1'b1, 0));
    send_cmd(make_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_PIXEL, 127, 295, 0, 0, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_PIXEL, -512, 511, -512, 511, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_LINE, -512, -512, 511, 511, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_LINE, 100, 3, 5, 290, 0, 1'b1, 0));
    send_cmd(make_cmd(ACT_LINE, 7, 7, 7, 7, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_RECT, 511, 511, -512, -512, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_RECT, 10, 20, 30, 40, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_FILL_RECT, 60, 60, 40, 80, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_CIRCLE, 511, -512, 0, 0, 511, 1'b0, 0));
    send_cmd(make_cmd(ACT_CIRCLE, 64, 150, 0, 0, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_CIRCLE, 64, 150, 0, 0, 60, 1'b0, 0));
    send_cmd(make_cmd(ACT_FILL_CIRCLE, 30, 250, 0, 0, 20, 1'b0, 0));
    send_cmd(make_cmd(ACT_FILL_CIRCLE, 64, 100, 0, 0, 5, 1'b1, 0));
    send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 1'b0, 0));
    send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 1'b1, STORE_BYTES - 1));
    send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 1'b0, 8191));
    send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 1'b0, 1000));
    drain();

    // Random phases; each opens with a configuration and a clear. The first
    // phases pin the register extremes, the last runs without idling.
    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase != 7);
      case (phase)
        0: begin w = 8;   h = 1;   end
        1: begin w = 128; h = 296; end
        2: begin w = 13;  h = 17;  end
        default: begin
          w = $urandom_range(8, 128);
          h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 296) : $urandom_range(1, 64);
        end
      endcase
      write_reg(REG_ROTATION, (phase < 4) ? phase : $urandom_range(0, 3));
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_POLARITY, phase & 1);
      if (phase == 3) long_hold = 1'b1;
      send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, $urandom_range(0, 1), 0));
      repeat (150) send_cmd(random_cmd());
      drain();
    end

    $display("Commands: clear %0d, pixel %0d, line %0d, rect %0d, filled rect %0d",
             cmds_by_action[ACT_CLEAR], cmds_by_action[ACT_PIXEL],
             cmds_by_action[ACT_LINE], cmds_by_action[ACT_RECT],
             cmds_by_action[ACT_FILL_RECT]);
    $display("Circles %0d, filled circles %0d, reads %0d (%0d read answers checked)",
             cmds_by_action[ACT_CIRCLE], cmds_by_action[ACT_FILL_CIRCLE],
             cmds_by_action[ACT_READ], reads_checked);
    if (sb.pending() != 0) report($sformatf("%0d answers never arrived", sb.pending()));
    if (mismatches == 0) begin
      $display("** monochrome_shape_drawing_engine: PASSED **");
    end else begin
      $display("** monochrome_shape_drawing_engine: FAILED **");
    end
    $finish;
  end

endmodule
